// ----- rtl/ipt_pkg.sv -----
// Shared constants and types for the image error pan/tilt position tracker.
package ipt_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int ANGLE_BITS = 16;
  localparam int GAIN_W     = 16;
  localparam int RPP_W      = 24;
  localparam int ERR_W      = PIXEL_BITS + 1;
  localparam int DERR_W     = PIXEL_BITS + 2;
  localparam int HI_W       = PIXEL_BITS + 4;
  localparam int ACC_W      = HI_W + 1;
  localparam int SUM_W      = HI_W + GAIN_W;
  localparam int MAG_W      = SUM_W - 1;
  localparam int CORR_W     = MAG_W + 2;
  localparam int CNT_W      = $clog2(RPP_W);
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_SETPOINT_X = 3'd0;
  localparam logic [2:0] REG_SETPOINT_Y = 3'd1;
  localparam logic [2:0] REG_GAIN_P     = 3'd2;
  localparam logic [2:0] REG_GAIN_PREV  = 3'd3;
  localparam logic [2:0] REG_GAIN_D     = 3'd4;
  localparam logic [2:0] REG_RAD_PER_PX = 3'd5;
  localparam logic [2:0] REG_DEADBAND_X = 3'd6;
  localparam logic [2:0] REG_DEADBAND_Y = 3'd7;

  localparam logic [PIXEL_BITS-1:0] RST_SETPOINT_X = PIXEL_BITS'(320);
  localparam logic [PIXEL_BITS-1:0] RST_SETPOINT_Y = PIXEL_BITS'(240);
  localparam logic [GAIN_W-1:0]     RST_GAIN_P     = GAIN_W'(3686);
  localparam logic [GAIN_W-1:0]     RST_GAIN_PREV  = GAIN_W'(819);
  localparam logic [GAIN_W-1:0]     RST_GAIN_D     = GAIN_W'(41);
  localparam logic [RPP_W-1:0]      RST_RAD_PER_PX = RPP_W'(28366);
  localparam logic [PIXEL_BITS-1:0] RST_DEADBAND   = PIXEL_BITS'(10);

  typedef struct packed {
    logic load;
    logic mul1;
    logic absv;
    logic mul2;
    logic rnd;
  } lane_ctl_t;

endpackage

// ----- rtl/ipt_if.sv -----
// Request and result channel interfaces for the position tracker.
interface ipt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     req_type;
  logic [ipt_pkg::PIXEL_BITS-1:0]           center_x;
  logic [ipt_pkg::PIXEL_BITS-1:0]           center_y;
  logic signed [ipt_pkg::ANGLE_BITS-1:0]    pan_angle;
  logic signed [ipt_pkg::ANGLE_BITS-1:0]    tilt_angle;

  modport source (output valid, req_type, center_x, center_y, pan_angle, tilt_angle,
                  input ready);
  modport sink   (input valid, req_type, center_x, center_y, pan_angle, tilt_angle,
                  output ready);
endinterface

interface ipt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ipt_pkg::ANGLE_BITS-1:0]    pan_command;
  logic signed [ipt_pkg::ANGLE_BITS-1:0]    tilt_command;
  logic                                     saturated;

  modport source (output valid, pan_command, tilt_command, saturated, input ready);
  modport sink   (input valid, pan_command, tilt_command, saturated, output ready);
endinterface

// ----- rtl/ipt_axis.sv -----
// One axis lane: bit-serial gain sum, deadband, bit-serial scale, rounding and clipping.
module ipt_axis (
  input  logic                                  clk,
  input  ipt_pkg::lane_ctl_t                    ctl,
  input  logic                                  invert,
  input  logic signed [ipt_pkg::ERR_W-1:0]      err,
  input  logic signed [ipt_pkg::ERR_W-1:0]      perr,
  input  logic signed [ipt_pkg::DERR_W-1:0]     derr,
  input  logic [ipt_pkg::PIXEL_BITS-1:0]        band,
  input  logic [ipt_pkg::GAIN_W-1:0]            gain_p,
  input  logic [ipt_pkg::GAIN_W-1:0]            gain_prev,
  input  logic [ipt_pkg::GAIN_W-1:0]            gain_d,
  input  logic [ipt_pkg::RPP_W-1:0]             rpp,
  input  logic signed [ipt_pkg::ANGLE_BITS-1:0] pos,
  output logic signed [ipt_pkg::ANGLE_BITS-1:0] cmd,
  output logic                                  sat
);

  localparam int DW = ipt_pkg::CORR_W + 1;
  localparam logic signed [DW-1:0] HI_LIM =
    {{(DW-ipt_pkg::ANGLE_BITS+1){1'b0}}, {(ipt_pkg::ANGLE_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] LO_LIM = ~HI_LIM;

  logic signed [ipt_pkg::ERR_W-1:0]      err_r, perr_r;
  logic signed [ipt_pkg::DERR_W-1:0]     derr_r;
  logic [ipt_pkg::GAIN_W-1:0]            gp_r, gi_r, gd_r;
  logic signed [ipt_pkg::HI_W-1:0]       hi_r;
  logic [ipt_pkg::GAIN_W-1:0]            lo_r;
  logic                                  act_r;
  logic signed [ipt_pkg::ANGLE_BITS-1:0] pos_r;
  logic [ipt_pkg::RPP_W-1:0]             rpp_r;
  logic                                  neg_r;
  logic [ipt_pkg::MAG_W-1:0]             mag_r;
  logic [ipt_pkg::MAG_W-1:0]             phi_r;
  logic [ipt_pkg::RPP_W-1:0]             plo_r;
  logic signed [ipt_pkg::CORR_W-1:0]     corr_r;

  logic [ipt_pkg::ERR_W-1:0]             emag;
  logic signed [ipt_pkg::ACC_W-1:0]      t_p, t_i, t_d, acc;
  logic signed [ipt_pkg::SUM_W-1:0]      sum, sum_neg;
  logic [ipt_pkg::MAG_W:0]               ps, rsum;
  logic signed [ipt_pkg::CORR_W-1:0]     corr_val;
  logic signed [DW-1:0]                  pos_x, corr_x, diff;

  assign emag = err[ipt_pkg::ERR_W-1] ? ipt_pkg::ERR_W'(-err) : ipt_pkg::ERR_W'(err);

  assign t_p = gp_r[0] ? {{(ipt_pkg::ACC_W-ipt_pkg::ERR_W){err_r[ipt_pkg::ERR_W-1]}}, err_r}
                       : '0;
  assign t_i = gi_r[0] ? {{(ipt_pkg::ACC_W-ipt_pkg::ERR_W){perr_r[ipt_pkg::ERR_W-1]}}, perr_r}
                       : '0;
  assign t_d = gd_r[0] ? {{(ipt_pkg::ACC_W-ipt_pkg::DERR_W){derr_r[ipt_pkg::DERR_W-1]}}, derr_r}
                       : '0;
  assign acc = {hi_r[ipt_pkg::HI_W-1], hi_r} + t_p + t_i + t_d;

  assign sum     = {hi_r, lo_r};
  assign sum_neg = -sum;

  assign ps   = {1'b0, phi_r} + {1'b0, (rpp_r[0] ? mag_r : {ipt_pkg::MAG_W{1'b0}})};
  assign rsum = {1'b0, phi_r} + (ipt_pkg::MAG_W+1)'(plo_r[ipt_pkg::RPP_W-1]);
  assign corr_val = neg_r ? -$signed({1'b0, rsum}) : $signed({1'b0, rsum});

  assign pos_x  = {{(DW-ipt_pkg::ANGLE_BITS){pos_r[ipt_pkg::ANGLE_BITS-1]}}, pos_r};
  assign corr_x = {corr_r[ipt_pkg::CORR_W-1], corr_r};
  assign diff   = invert ? (corr_x - pos_x) : (pos_x - corr_x);

  always_comb begin
    sat = 1'b0;
    cmd = diff[ipt_pkg::ANGLE_BITS-1:0];
    if (diff > HI_LIM) begin
      sat = 1'b1;
      cmd = HI_LIM[ipt_pkg::ANGLE_BITS-1:0];
    end else if (diff < LO_LIM) begin
      sat = 1'b1;
      cmd = LO_LIM[ipt_pkg::ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      err_r  <= err;
      perr_r <= perr;
      derr_r <= derr;
      gp_r   <= gain_p;
      gi_r   <= gain_prev;
      gd_r   <= gain_d;
      hi_r   <= '0;
      lo_r   <= '0;
      act_r  <= emag > {1'b0, band};
      pos_r  <= pos;
      rpp_r  <= rpp;
    end
    if (ctl.mul1) begin
      hi_r <= acc[ipt_pkg::ACC_W-1:1];
      lo_r <= {acc[0], lo_r[ipt_pkg::GAIN_W-1:1]};
      gp_r <= gp_r >> 1;
      gi_r <= gi_r >> 1;
      gd_r <= gd_r >> 1;
    end
    if (ctl.absv) begin
      neg_r <= sum[ipt_pkg::SUM_W-1];
      if (!act_r)
        mag_r <= '0;
      else if (sum[ipt_pkg::SUM_W-1])
        mag_r <= sum_neg[ipt_pkg::MAG_W-1:0];
      else
        mag_r <= sum[ipt_pkg::MAG_W-1:0];
      phi_r <= '0;
      plo_r <= '0;
    end
    if (ctl.mul2) begin
      phi_r <= ps[ipt_pkg::MAG_W:1];
      plo_r <= {ps[0], plo_r[ipt_pkg::RPP_W-1:1]};
      rpp_r <= rpp_r >> 1;
    end
    if (ctl.rnd)
      corr_r <= corr_val;
  end

endmodule

// ----- rtl/image_error_pd_position_tracker.sv -----
// Top level: request intake, sequencer, register file and result register.
// Position requests give no result and leave the sequencer idle, so input stays ready.
// A target request's result is built over the 16 gain bits, a sign step, the 24 scale bits,
// a round step and a clip into the result register; both axes run in parallel.
// One target request is in work at a time; input waits until its result is registered.
// Synchronous active-low reset restores register defaults, clears errors and positions.
module image_error_pd_position_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  ipt_in_if.sink                         in_ch,
  ipt_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ipt_pkg::ADDR_W-1:0]     paddr,
  input  logic [ipt_pkg::DATA_W-1:0]     pwdata,
  output logic [ipt_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                            state_r, state_nxt;
  logic [ipt_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;

  logic [ipt_pkg::PIXEL_BITS-1:0]        sp_x_r, sp_y_r, db_x_r, db_y_r;
  logic [ipt_pkg::GAIN_W-1:0]            gp_r, gi_r, gd_r;
  logic [ipt_pkg::RPP_W-1:0]             rpp_r;

  logic signed [ipt_pkg::ERR_W-1:0]      pan_err_r, tilt_err_r;
  logic                                  first_r;
  logic signed [ipt_pkg::ANGLE_BITS-1:0] pan_pos_r, tilt_pos_r;

  logic                                  out_valid_r;
  logic signed [ipt_pkg::ANGLE_BITS-1:0] pan_cmd_r, tilt_cmd_r;
  logic                                  sat_r;

  logic                                  in_acc, tgt_acc, pos_acc, fin_load, cfg_wr;
  logic signed [ipt_pkg::ERR_W-1:0]      ex, ey;
  logic signed [ipt_pkg::DERR_W-1:0]     dx, dy;
  ipt_pkg::lane_ctl_t                    ctl;
  logic signed [ipt_pkg::ANGLE_BITS-1:0] pan_cmd, tilt_cmd;
  logic                                  pan_sat, tilt_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign tgt_acc = in_acc && !in_ch.req_type;
  assign pos_acc = in_acc && in_ch.req_type;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign ex = ipt_pkg::ERR_W'({1'b0, in_ch.center_x}) - ipt_pkg::ERR_W'({1'b0, sp_x_r});
  assign ey = ipt_pkg::ERR_W'({1'b0, in_ch.center_y}) - ipt_pkg::ERR_W'({1'b0, sp_y_r});
  assign dx = first_r ? '0 :
              ({ex[ipt_pkg::ERR_W-1], ex} - {pan_err_r[ipt_pkg::ERR_W-1], pan_err_r});
  assign dy = first_r ? '0 :
              ({ey[ipt_pkg::ERR_W-1], ey} - {tilt_err_r[ipt_pkg::ERR_W-1], tilt_err_r});

  assign ctl.load = tgt_acc;
  assign ctl.mul1 = (state_r == S_MUL1);
  assign ctl.absv = (state_r == S_ABS);
  assign ctl.mul2 = (state_r == S_MUL2);
  assign ctl.rnd  = (state_r == S_RND);

  ipt_axis u_pan (
    .clk       (clk),
    .ctl       (ctl),
    .invert    (1'b0),
    .err       (ex),
    .perr      (pan_err_r),
    .derr      (dx),
    .band      (db_x_r),
    .gain_p    (gp_r),
    .gain_prev (gi_r),
    .gain_d    (gd_r),
    .rpp       (rpp_r),
    .pos       (pan_pos_r),
    .cmd       (pan_cmd),
    .sat       (pan_sat)
  );

  ipt_axis u_tilt (
    .clk       (clk),
    .ctl       (ctl),
    .invert    (1'b1),
    .err       (ey),
    .perr      (tilt_err_r),
    .derr      (dy),
    .band      (db_y_r),
    .gain_p    (gp_r),
    .gain_prev (gi_r),
    .gain_d    (gd_r),
    .rpp       (rpp_r),
    .pos       (tilt_pos_r),
    .cmd       (tilt_cmd),
    .sat       (tilt_sat)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (tgt_acc) begin
          state_nxt = S_MUL1;
          cnt_nxt   = ipt_pkg::CNT_W'(ipt_pkg::GAIN_W - 1);
        end
      end
      S_MUL1: begin
        if (cnt_r == '0)
          state_nxt = S_ABS;
        else
          cnt_nxt = cnt_r - 1'b1;
      end
      S_ABS: begin
        state_nxt = S_MUL2;
        cnt_nxt   = ipt_pkg::CNT_W'(ipt_pkg::RPP_W - 1);
      end
      S_MUL2: begin
        if (cnt_r == '0)
          state_nxt = S_RND;
        else
          cnt_nxt = cnt_r - 1'b1;
      end
      S_RND: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_load)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      ipt_pkg::REG_SETPOINT_X: prdata = ipt_pkg::DATA_W'(sp_x_r);
      ipt_pkg::REG_SETPOINT_Y: prdata = ipt_pkg::DATA_W'(sp_y_r);
      ipt_pkg::REG_GAIN_P:     prdata = ipt_pkg::DATA_W'(gp_r);
      ipt_pkg::REG_GAIN_PREV:  prdata = ipt_pkg::DATA_W'(gi_r);
      ipt_pkg::REG_GAIN_D:     prdata = ipt_pkg::DATA_W'(gd_r);
      ipt_pkg::REG_RAD_PER_PX: prdata = ipt_pkg::DATA_W'(rpp_r);
      ipt_pkg::REG_DEADBAND_X: prdata = ipt_pkg::DATA_W'(db_x_r);
      ipt_pkg::REG_DEADBAND_Y: prdata = ipt_pkg::DATA_W'(db_y_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sp_x_r      <= ipt_pkg::RST_SETPOINT_X;
      sp_y_r      <= ipt_pkg::RST_SETPOINT_Y;
      gp_r        <= ipt_pkg::RST_GAIN_P;
      gi_r        <= ipt_pkg::RST_GAIN_PREV;
      gd_r        <= ipt_pkg::RST_GAIN_D;
      rpp_r       <= ipt_pkg::RST_RAD_PER_PX;
      db_x_r      <= ipt_pkg::RST_DEADBAND;
      db_y_r      <= ipt_pkg::RST_DEADBAND;
      pan_err_r   <= '0;
      tilt_err_r  <= '0;
      first_r     <= 1'b1;
      pan_pos_r   <= '0;
      tilt_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ipt_pkg::REG_SETPOINT_X: sp_x_r <= pwdata[ipt_pkg::PIXEL_BITS-1:0];
          ipt_pkg::REG_SETPOINT_Y: sp_y_r <= pwdata[ipt_pkg::PIXEL_BITS-1:0];
          ipt_pkg::REG_GAIN_P:     gp_r   <= pwdata[ipt_pkg::GAIN_W-1:0];
          ipt_pkg::REG_GAIN_PREV:  gi_r   <= pwdata[ipt_pkg::GAIN_W-1:0];
          ipt_pkg::REG_GAIN_D:     gd_r   <= pwdata[ipt_pkg::GAIN_W-1:0];
          ipt_pkg::REG_RAD_PER_PX: rpp_r  <= pwdata[ipt_pkg::RPP_W-1:0];
          ipt_pkg::REG_DEADBAND_X: db_x_r <= pwdata[ipt_pkg::PIXEL_BITS-1:0];
          ipt_pkg::REG_DEADBAND_Y: db_y_r <= pwdata[ipt_pkg::PIXEL_BITS-1:0];
          default: ;
        endcase
      end
      if (pos_acc) begin
        pan_pos_r  <= in_ch.pan_angle;
        tilt_pos_r <= in_ch.tilt_angle;
      end
      if (tgt_acc) begin
        pan_err_r  <= ex;
        tilt_err_r <= ey;
        first_r    <= 1'b0;
      end
      if (fin_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      pan_cmd_r  <= pan_cmd;
      tilt_cmd_r <= tilt_cmd;
      sat_r      <= pan_sat || tilt_sat;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pan_command  = pan_cmd_r;
  assign out_ch.tilt_command = tilt_cmd_r;
  assign out_ch.saturated    = sat_r;

endmodule
